>>> rtl/core/pgtw_pkg.sv
// Package for the four-level page table walker: codes, queue entry and
// result types, walker states and address constants. No dependencies.
`timescale 1ns / 1ps

package pgtw_pkg;

	localparam int unsigned PHYS_ADDR_BITS = 48;
	localparam int unsigned VA_W           = 48;
	localparam int unsigned ENTRY_W        = 64;

	// Frame bits of an entry: PHYS_ADDR_BITS-1 down to 12, kept to the 48-bit result.
	localparam logic [63:0] FRAME_MASK_64 =
		((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'hFFF;
	localparam logic [VA_W-1:0] FRAME_MASK = FRAME_MASK_64[VA_W-1:0];

	localparam int unsigned PRESENT_POS = 0;
	localparam int unsigned LARGE_POS   = 7;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic KIND_REQ  = 1'b0;
	localparam logic KIND_RESP = 1'b1;

	localparam logic RK_READ = 1'b0;
	localparam logic RK_DONE = 1'b1;

	localparam logic [1:0] PS_4K = 2'd0;
	localparam logic [1:0] PS_2M = 2'd1;
	localparam logic [1:0] PS_1G = 2'd2;

	typedef enum logic [2:0] {
		WS_IDLE,
		WS_L0,
		WS_L1,
		WS_L2,
		WS_L3
	} walk_state_t;

	// One classified word in the queue. For a request, addr_a holds the
	// virtual address and addr_b the first entry address. For a response,
	// addr_b holds the frame and the flags say present and large page.
	typedef struct packed {
		logic            is_req;
		logic            present;
		logic            big_page;
		logic [VA_W-1:0] addr_a;
		logic [VA_W-1:0] addr_b;
	} queue_entry_t;

	typedef struct packed {
		logic            result_kind;
		logic [VA_W-1:0] read_addr;
		logic [VA_W-1:0] phys_addr;
		logic            fault;
		logic [1:0]      page_size;
	} result_t;

endpackage

>>> rtl/core/pgtw_front.sv
// Front end of the walker: classifies each input word and precomputes what
// the back end needs. Depends on pgtw_pkg.
`timescale 1ns / 1ps

module pgtw_front import pgtw_pkg::*; (
	input  logic               kind,
	input  logic [VA_W-1:0]    virt_addr,
	input  logic [VA_W-1:0]    table_base,
	input  logic [ENTRY_W-1:0] read_data,
	input  logic               read_ok,
	output queue_entry_t       entry
);

	logic [ENTRY_W-1:0] pte;
	logic [VA_W-1:0]    top_addr;

	// A failed read is taken as the zero entry.
	assign pte      = read_ok ? read_data : '0;
	assign top_addr = table_base + {36'd0, virt_addr[47:39], 3'd0};

	always_comb begin
		entry.is_req   = (kind == KIND_REQ);
		entry.present  = pte[PRESENT_POS];
		entry.big_page = pte[LARGE_POS];
		entry.addr_a   = virt_addr;
		if (kind == KIND_REQ) begin
			entry.addr_b = top_addr;
		end else begin
			entry.addr_b = pte[VA_W-1:0] & FRAME_MASK;
		end
	end

endmodule

>>> rtl/core/pgtw_queue.sv
// Short queue between the front and back ends of the walker.
// Depends on pgtw_pkg.
`timescale 1ns / 1ps

module pgtw_queue import pgtw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t push_data,
	input  logic         pop,
	output queue_entry_t pop_data,
	output logic         full,
	output logic         not_empty
);

	queue_entry_t            slots_q [QDEPTH];
	logic [QPTR_W-1:0]       wr_ptr_q;
	logic [QPTR_W-1:0]       rd_ptr_q;
	logic [QCNT_W-1:0]       count_q;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/pgtw_back.sv
// Back end of the walker: walk state machine, address adder and the output
// register. Depends on pgtw_pkg.
`timescale 1ns / 1ps

module pgtw_back import pgtw_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_not_empty,
	input  queue_entry_t q_data,
	output logic         q_pop,
	output logic         out_valid,
	input  logic         out_stall,
	output result_t      result
);

	walk_state_t     state_q, state_d;
	logic [VA_W-1:0] va_q;
	logic            load_va;
	logic            emit;
	result_t         res_d;
	result_t         res_q;
	logic            out_valid_q;
	logic [VA_W-1:0] addend;
	logic [VA_W-1:0] sum_addr;
	logic [8:0]      idx;

	assign q_pop = q_not_empty && (!out_valid_q || !out_stall);

	// Index of the next level's entry, or page offset on a large or last page.
	always_comb begin
		case (state_q)
			WS_L0:   idx = va_q[38:30];
			WS_L1:   idx = va_q[29:21];
			default: idx = va_q[20:12];
		endcase
		addend = {36'd0, idx, 3'd0};
		if (state_q == WS_L3) begin
			addend = {36'd0, va_q[11:0]};
		end else if (q_data.big_page && state_q == WS_L1) begin
			addend = {18'd0, va_q[29:0]};
		end else if (q_data.big_page && state_q == WS_L2) begin
			addend = {27'd0, va_q[20:0]};
		end
	end

	assign sum_addr = q_data.addr_b + addend;

	always_comb begin
		state_d = state_q;
		load_va = 1'b0;
		emit    = 1'b0;
		res_d   = '0;
		if (q_pop) begin
			if (q_data.is_req) begin
				if (state_q == WS_IDLE) begin
					state_d         = WS_L0;
					load_va         = 1'b1;
					emit            = 1'b1;
					res_d.read_addr = q_data.addr_b;
				end
			end else if (state_q != WS_IDLE) begin
				emit = 1'b1;
				if (!q_data.present) begin
					state_d           = WS_IDLE;
					res_d.result_kind = RK_DONE;
					res_d.fault       = 1'b1;
				end else begin
					case (state_q)
						WS_L0: begin
							state_d         = WS_L1;
							res_d.read_addr = sum_addr;
						end
						WS_L1: begin
							if (q_data.big_page) begin
								state_d           = WS_IDLE;
								res_d.result_kind = RK_DONE;
								res_d.phys_addr   = sum_addr;
								res_d.page_size   = PS_1G;
							end else begin
								state_d         = WS_L2;
								res_d.read_addr = sum_addr;
							end
						end
						WS_L2: begin
							if (q_data.big_page) begin
								state_d           = WS_IDLE;
								res_d.result_kind = RK_DONE;
								res_d.phys_addr   = sum_addr;
								res_d.page_size   = PS_2M;
							end else begin
								state_d         = WS_L3;
								res_d.read_addr = sum_addr;
							end
						end
						default: begin
							state_d           = WS_IDLE;
							res_d.result_kind = RK_DONE;
							res_d.phys_addr   = sum_addr;
							res_d.page_size   = PS_4K;
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= WS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_va) begin
			va_q <= q_data.addr_a;
		end
		if (emit) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

>>> rtl/core/four_level_page_table_walker_unit.sv
// Top level of the four-level page table walker: front end, queue and back end.
// Depends on pgtw_pkg, pgtw_front, pgtw_queue and pgtw_back.
`timescale 1ns / 1ps

// Usage. The input channel (in_valid / in_stall) carries one word a cycle:
// either a translation request (kind = 0, virt_addr, table_base) or a memory
// read response (kind = 1, read_data, read_ok). The output channel
// (out_valid / out_stall) carries memory read requests (result_kind = 0,
// read_addr) and finished translations (result_kind = 1, phys_addr,
// page_size or fault). The user returns one response for every read request.
// A request that arrives during a walk, and a response that arrives with no
// walk open, are dropped and give no output word.
// Throughput is one input word per cycle while in_stall is low. An accepted
// word goes into a four-entry queue; the back end takes one word a cycle from
// it while the output is not stalled, and each result it makes is held in the
// output register. The per-word cost is one pass through the walk state
// machine and its single address adder. When the receiver stalls, the output
// word holds and the queue fills; in_stall rises once all four entries are taken.
// Reset clears the walk state, the queue and the output valid flag; no walk is
// open afterwards.

module four_level_page_table_walker_unit import pgtw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [VA_W-1:0]    virt_addr,
	input  logic [VA_W-1:0]    table_base,
	input  logic [ENTRY_W-1:0] read_data,
	input  logic               read_ok,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               result_kind,
	output logic [VA_W-1:0]    read_addr,
	output logic [VA_W-1:0]    phys_addr,
	output logic               fault,
	output logic [1:0]         page_size
);

	queue_entry_t front_entry;
	queue_entry_t q_data;
	logic         q_full;
	logic         q_not_empty;
	logic         q_pop;
	logic         push;
	result_t      result;

	// The front end classifies the word and computes the first entry address.
	pgtw_front u_front (
		.kind       (kind),
		.virt_addr  (virt_addr),
		.table_base (table_base),
		.read_data  (read_data),
		.read_ok    (read_ok),
		.entry      (front_entry)
	);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	pgtw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_entry),
		.pop       (q_pop),
		.pop_data  (q_data),
		.full      (q_full),
		.not_empty (q_not_empty)
	);

	// The back end walks the levels and owns the output register.
	pgtw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result)
	);

	assign result_kind = result.result_kind;
	assign read_addr   = result.read_addr;
	assign phys_addr   = result.phys_addr;
	assign fault       = result.fault;
	assign page_size   = result.page_size;

endmodule
